// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the blit engine.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is asserted.
`define FBDR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame blit assertion failed");

// Same-cycle implication built on the plain form.
`define FBDR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  `FBDR_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// File: src/fbdr_pkg.sv
// Shared types and constants of the frame blit engine.
// Depends on nothing; used by the interfaces, the store and the top level.
package fbdr_pkg;

  localparam int MAX_DIM_DEF      = 256;
  localparam int FRAME_PIXELS_DEF = 65536;

  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;
  // Pixel address before the store range check: (row sum) * width + column sum.
  localparam int LIN_ADDR_W = 20;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_PIXEL  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NO_FRAG = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_e;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } rect_t;

  typedef struct packed {
    logic en;
    logic we;
  } store_cmd_t;

endpackage

// File: src/fbdr_req_if.sv
// Request channel of the frame blit engine: valid, ready and one request word.
// Depends on fbdr_pkg for the field widths.
interface fbdr_req_if
  import fbdr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [SIZE_W-1:0]  size_w;
  logic [SIZE_W-1:0]  size_h;
  logic               untracked;
  logic [CHAN_W-1:0]  chan0;
  logic [CHAN_W-1:0]  chan1;
  logic [CHAN_W-1:0]  chan2;
  logic [CHAN_W-1:0]  chan3;

  modport source (
    output valid, req_type, pos_x, pos_y, size_w, size_h, untracked,
           chan0, chan1, chan2, chan3,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, size_w, size_h, untracked,
           chan0, chan1, chan2, chan3,
    output ready
  );
endinterface

// Response channel: valid, ready and one result word.
interface fbdr_rsp_if
  import fbdr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               frag_done;
  logic               rect_valid;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [SIZE_W-1:0]  rect_w;
  logic [SIZE_W-1:0]  rect_h;
  logic [CHAN_W-1:0]  read_r;
  logic [CHAN_W-1:0]  read_g;
  logic [CHAN_W-1:0]  read_b;

  modport source (
    output valid, status, frag_done, rect_valid, rect_x, rect_y, rect_w, rect_h,
           read_r, read_g, read_b,
    input  ready
  );
  modport sink (
    input  valid, status, frag_done, rect_valid, rect_x, rect_y, rect_w, rect_h,
           read_r, read_g, read_b,
    output ready
  );
endinterface

// File: src/frame_blit_dirty_rect.sv
// Top level of the frame blit engine with dirty rectangle tracking.
// Depends on fbdr_pkg, the channel interfaces, fbdr_store and assert_macros.svh.
//
// Usage: request words arrive on req_i and result words leave on rsp_o, both
// valid/ready channels; a word moves when valid and ready are high at a rising
// edge. A fragment header (x, y, w, h) opens a rectangle that the following
// pixel words fill in row-major order; clear and read-pixel requests share the
// same channel. Every request yields exactly one result word, in order.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the pixel
// format and the frame size; it should be written only while no request is in
// flight.
// Throughput is one request per cycle unless the receiver stalls. Header checks,
// the dirty rectangle and the fill cursor are updated in the accept cycle, and
// the single pixel address multiplier sits there too. The frame store sees at
// most one write or one read per request as the word moves into the output
// register, and the result is presented from that register.
// When the receiver stalls, the output register and the stage in front of it
// hold their words, and req_i.ready drops only once both are full.
// Reset clears the dirty rectangle, closes any open fragment and restores the
// registers to RGB order and a 256 by 256 frame. The store keeps its contents
// across reset and needs no clearing pass; unwritten pixels read back as junk.
module frame_blit_dirty_rect
  import fbdr_pkg::*;
#(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fbdr_req_if.sink             req_i,
  fbdr_rsp_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(FRAME_PIXELS);
  localparam int XW = AW + LIN_ADDR_W;

  // Configuration registers.
  logic [1:0]        pix_fmt_q;
  logic [SIZE_W-1:0] frame_w_q, frame_h_q;

  // Dirty rectangle and fragment cursor.
  logic               dirty_valid_q, dirty_valid_d;
  logic [COORD_W-1:0] dirty_x_q, dirty_x_d, dirty_y_q, dirty_y_d;
  logic [SIZE_W-1:0]  dirty_w_q, dirty_w_d, dirty_h_q, dirty_h_d;
  logic               frag_open_q, frag_open_d;
  logic [COORD_W-1:0] frag_x_q, frag_x_d, frag_y_q, frag_y_d;
  logic [SIZE_W-1:0]  frag_w_q, frag_w_d, frag_h_q, frag_h_d;
  logic [SIZE_W-1:0]  cur_col_q, cur_col_d, cur_row_q, cur_row_d;

  // Pipeline stages: stage one holds the store access, stage two the result.
  logic               s1_valid_q, s2_valid_q;
  status_e            s1_status_q, s1_status_d, s2_status_q;
  logic               s1_done_q, s1_done_d, s2_done_q;
  rect_t              s1_rect_q, s1_rect_d, s2_rect_q;
  logic               s1_we_q, s1_we_d, s1_re_q, s1_re_d, s2_rd_q;
  logic [AW-1:0]      s1_addr_q;
  logic [PIXEL_W-1:0] s1_wdata_q, s1_wdata_d;

  logic acc, adv2;

  assign adv2        = s1_valid_q && (!s2_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || adv2;
  assign acc         = req_i.valid && req_i.ready;

  // Effective frame size, clamped to the largest supported dimension.
  logic [SIZE_W-1:0] fw, fh;
  assign fw = (32'(frame_w_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : frame_w_q;
  assign fh = (32'(frame_h_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : frame_h_q;

  logic [SIZE_W:0] px10, py10, sw10, sh10, fw10, fh10;
  assign px10 = {2'b00, req_i.pos_x};
  assign py10 = {2'b00, req_i.pos_y};
  assign sw10 = {1'b0, req_i.size_w};
  assign sh10 = {1'b0, req_i.size_h};
  assign fw10 = {1'b0, fw};
  assign fh10 = {1'b0, fh};

  logic pos_out, hdr_reject;
  assign pos_out    = (px10 >= fw10) || (py10 >= fh10);
  assign hdr_reject = pos_out || (px10 + sw10 > fw10) || (py10 + sh10 > fh10);

  // Bounding-box union of the header rectangle with the current one.
  logic [COORD_W-1:0] grow_l, grow_t;
  logic [SIZE_W:0]    r1, r2, b1, b2, grow_r, grow_b, diff_w, diff_h;
  assign grow_l = (req_i.pos_x < dirty_x_q) ? req_i.pos_x : dirty_x_q;
  assign grow_t = (req_i.pos_y < dirty_y_q) ? req_i.pos_y : dirty_y_q;
  assign r1     = px10 + sw10;
  assign b1     = py10 + sh10;
  assign r2     = {2'b00, dirty_x_q} + {1'b0, dirty_w_q};
  assign b2     = {2'b00, dirty_y_q} + {1'b0, dirty_h_q};
  assign grow_r = (r1 > r2) ? r1 : r2;
  assign grow_b = (b1 > b2) ? b1 : b2;
  assign diff_w = grow_r - {2'b00, grow_l};
  assign diff_h = grow_b - {2'b00, grow_t};

  // One shared address multiplier: pixel writes use the cursor, reads the
  // requested position.
  logic                  is_pixel;
  logic [SIZE_W:0]       mul_a, add_b;
  logic [2*SIZE_W:0]     prod;
  logic [LIN_ADDR_W-1:0] lin_addr;
  logic [XW-1:0]         addr_ext;
  logic                  in_range;

  assign is_pixel = (req_e'(req_i.req_type) == REQ_PIXEL);
  assign mul_a    = is_pixel ? ({2'b00, frag_y_q} + {1'b0, cur_row_q}) : py10;
  assign add_b    = is_pixel ? ({2'b00, frag_x_q} + {1'b0, cur_col_q}) : px10;
  assign prod     = mul_a * fw;
  assign lin_addr = {1'b0, prod} + {{(LIN_ADDR_W-SIZE_W-1){1'b0}}, add_b};
  assign addr_ext = {{AW{1'b0}}, lin_addr};
  assign in_range = (32'(lin_addr) < 32'(FRAME_PIXELS));

  logic [SIZE_W-1:0] col_inc, row_inc;
  assign col_inc = cur_col_q + 1'b1;
  assign row_inc = cur_row_q + 1'b1;

  always_comb begin
    dirty_valid_d = dirty_valid_q;
    dirty_x_d     = dirty_x_q;
    dirty_y_d     = dirty_y_q;
    dirty_w_d     = dirty_w_q;
    dirty_h_d     = dirty_h_q;
    frag_open_d   = frag_open_q;
    frag_x_d      = frag_x_q;
    frag_y_d      = frag_y_q;
    frag_w_d      = frag_w_q;
    frag_h_d      = frag_h_q;
    cur_col_d     = cur_col_q;
    cur_row_d     = cur_row_q;
    s1_status_d   = ST_OK;
    s1_done_d     = 1'b0;
    s1_we_d       = 1'b0;
    s1_re_d       = 1'b0;
    // BGR orders swap the first and third bytes; alpha never reaches the store.
    s1_wdata_d    = pix_fmt_q[0] ? {req_i.chan2, req_i.chan1, req_i.chan0}
                                 : {req_i.chan0, req_i.chan1, req_i.chan2};
    if (acc) begin
      case (req_e'(req_i.req_type))
        REQ_HEADER: begin
          // Any header abandons an open fragment.
          frag_open_d = 1'b0;
          if (hdr_reject) begin
            s1_status_d = ST_REJECT;
          end else if (req_i.size_w != '0 && req_i.size_h != '0) begin
            if (!req_i.untracked) begin
              dirty_valid_d = 1'b1;
              if (dirty_valid_q) begin
                dirty_x_d = grow_l;
                dirty_y_d = grow_t;
                dirty_w_d = diff_w[SIZE_W-1:0];
                dirty_h_d = diff_h[SIZE_W-1:0];
              end else begin
                dirty_x_d = req_i.pos_x;
                dirty_y_d = req_i.pos_y;
                dirty_w_d = req_i.size_w;
                dirty_h_d = req_i.size_h;
              end
            end
            frag_open_d = 1'b1;
            frag_x_d    = req_i.pos_x;
            frag_y_d    = req_i.pos_y;
            frag_w_d    = req_i.size_w;
            frag_h_d    = req_i.size_h;
            cur_col_d   = '0;
            cur_row_d   = '0;
          end
        end
        REQ_PIXEL: begin
          if (!frag_open_q) begin
            s1_status_d = ST_NO_FRAG;
          end else begin
            // A pixel that lands beyond the store is dropped; the cursor
            // still moves on.
            s1_we_d = in_range;
            if (col_inc >= frag_w_q) begin
              cur_col_d = '0;
              if (row_inc >= frag_h_q) begin
                cur_row_d   = '0;
                frag_open_d = 1'b0;
                s1_done_d   = 1'b1;
              end else begin
                cur_row_d = row_inc;
              end
            end else begin
              cur_col_d = col_inc;
            end
          end
        end
        REQ_CLEAR: begin
          dirty_valid_d = 1'b0;
          dirty_x_d     = '0;
          dirty_y_d     = '0;
          dirty_w_d     = '0;
          dirty_h_d     = '0;
        end
        REQ_READ: begin
          if (pos_out) begin
            s1_status_d = ST_REJECT;
          end else begin
            s1_re_d = in_range;
          end
        end
        default: begin
        end
      endcase
    end
    // Results report the rectangle as it stands after this request.
    s1_rect_d = '{valid: dirty_valid_d, x: dirty_x_d, y: dirty_y_d,
                  w: dirty_w_d, h: dirty_h_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_fmt_q <= '0;
      frame_w_q <= SIZE_W'(256);
      frame_h_q <= SIZE_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_PIXEL_FORMAT: pix_fmt_q <= cfg_data_i[1:0];
        CFG_FRAME_WIDTH:  frame_w_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_valid_q <= 1'b0;
      dirty_x_q     <= '0;
      dirty_y_q     <= '0;
      dirty_w_q     <= '0;
      dirty_h_q     <= '0;
      frag_open_q   <= 1'b0;
      frag_x_q      <= '0;
      frag_y_q      <= '0;
      frag_w_q      <= '0;
      frag_h_q      <= '0;
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
    end else begin
      dirty_valid_q <= dirty_valid_d;
      dirty_x_q     <= dirty_x_d;
      dirty_y_q     <= dirty_y_d;
      dirty_w_q     <= dirty_w_d;
      dirty_h_q     <= dirty_h_d;
      frag_open_q   <= frag_open_d;
      frag_x_q      <= frag_x_d;
      frag_y_q      <= frag_y_d;
      frag_w_q      <= frag_w_d;
      frag_h_q      <= frag_h_d;
      cur_col_q     <= cur_col_d;
      cur_row_q     <= cur_row_d;
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (adv2) begin
        s2_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Payload stages carry no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_status_q <= s1_status_d;
      s1_done_q   <= s1_done_d;
      s1_rect_q   <= s1_rect_d;
      s1_we_q     <= s1_we_d;
      s1_re_q     <= s1_re_d;
      s1_addr_q   <= addr_ext[AW-1:0];
      s1_wdata_q  <= s1_wdata_d;
    end
    if (adv2) begin
      s2_status_q <= s1_status_q;
      s2_done_q   <= s1_done_q;
      s2_rect_q   <= s1_rect_q;
      s2_rd_q     <= s1_re_q;
    end
  end

  // The store is accessed at most once per request, for a pixel write or a read, as it leaves stage one.
  store_cmd_t         store_cmd;
  logic [PIXEL_W-1:0] store_rdata;

  assign store_cmd.en = adv2 && (s1_we_q || s1_re_q);
  assign store_cmd.we = s1_we_q;

  fbdr_store #(
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (store_cmd),
    .addr_i  (s1_addr_q),
    .wdata_i (s1_wdata_q),
    .rdata_o (store_rdata)
  );

  assign rsp_o.valid      = s2_valid_q;
  assign rsp_o.status     = s2_status_q;
  assign rsp_o.frag_done  = s2_done_q;
  assign rsp_o.rect_valid = s2_rect_q.valid;
  assign rsp_o.rect_x     = s2_rect_q.x;
  assign rsp_o.rect_y     = s2_rect_q.y;
  assign rsp_o.rect_w     = s2_rect_q.w;
  assign rsp_o.rect_h     = s2_rect_q.h;
  assign rsp_o.read_r     = s2_rd_q ? store_rdata[23:16] : '0;
  assign rsp_o.read_g     = s2_rd_q ? store_rdata[15:8]  : '0;
  assign rsp_o.read_b     = s2_rd_q ? store_rdata[7:0]   : '0;

  // An empty dirty rectangle is always reported as all zeros.
  `FBDR_ASSERT_IMPLY(a_dirty_empty_zero, clk_i, rst_ni, !dirty_valid_q,
                     dirty_x_q == '0 && dirty_y_q == '0 && dirty_w_q == '0 && dirty_h_q == '0)
  // The fill cursor stays inside an open fragment.
  `FBDR_ASSERT_IMPLY(a_cursor_inside, clk_i, rst_ni, frag_open_q,
                     cur_col_q < frag_w_q && cur_row_q < frag_h_q)
  // Input back-pressure only appears with both stages occupied.
  `FBDR_ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, !req_i.ready, s1_valid_q && s2_valid_q)
  // A completed fragment is only ever reported with a good status.
  `FBDR_ASSERT_IMPLY(a_done_ok, clk_i, rst_ni, rsp_o.valid && rsp_o.frag_done,
                     rsp_o.status == ST_OK)

endmodule

// File: src/fbdr_store.sv
// Single-port frame store with a registered read port, one access per cycle.
// Depends on fbdr_pkg for the command struct and the pixel width.
module fbdr_store
  import fbdr_pkg::*;
#(
  parameter int DEPTH = FRAME_PIXELS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  store_cmd_t         cmd_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [PIXEL_W-1:0] wdata_i,
  output logic [PIXEL_W-1:0] rdata_o
);

  logic [PIXEL_W-1:0] mem_q [DEPTH];
  logic [PIXEL_W-1:0] rdata_q;

  // The read data register only moves on a read, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if (cmd_i.we) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: bench/frame_blit_dirty_rect_test.sv
// Self-checking bench for frame_blit_dirty_rect: directed rows, then random phases per setting.
// Depends on fbdr_pkg, the channel interfaces fbdr_req_if / fbdr_rsp_if and the RTL top level.
module frame_blit_dirty_rect_test;
  import fbdr_pkg::*;

  // One request word as the bench builds it, and one result word as it expects it.
  typedef struct packed {
    req_e               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic               untracked;
    logic [CHAN_W-1:0]  c0;
    logic [CHAN_W-1:0]  c1;
    logic [CHAN_W-1:0]  c2;
    logic [CHAN_W-1:0]  c3;
  } blit_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               done;
    logic               rv;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [SIZE_W-1:0]  rw;
    logic [SIZE_W-1:0]  rh;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
  } blit_rsp_t;

  // A directed row carries its own result only where that result is obvious.
  typedef struct packed {
    blit_req_t rq;
    logic      typed;
    blit_rsp_t want;
  } dir_row_t;

  // Register settings walked by the random part, extremes and out-of-range values among them.
  localparam int NUM_PHASES = 8;
  localparam int PH_FMT [NUM_PHASES] = '{0, 1, 2, 3, 1, 0, 3, 2};
  localparam int PH_W   [NUM_PHASES] = '{256, 16, 1, 255, 511, 0, 100, 256};
  localparam int PH_H   [NUM_PHASES] = '{256, 16, 1, 3, 300, 0, 256, 1};
  localparam int PH_LEN [NUM_PHASES] = '{300, 280, 150, 250, 250, 60, 300, 250};
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fbdr_req_if req_bus ();
  fbdr_rsp_if rsp_bus ();

  frame_blit_dirty_rect DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers, the fill cursor, the dirty
  // rectangle and every store word written so far (by linear address).
  // ---------------------------------------------------------------------------
  logic [1:0]  reg_format;
  logic [8:0]  reg_width;
  logic [8:0]  reg_height;

  bit          dirty_on;
  int          dirty_left, dirty_top, dirty_wid, dirty_hgt;
  bit          frag_live;
  int          frag_ox, frag_oy, frag_cols, frag_rows;
  int          cur_col, cur_row;

  logic [PIXEL_W-1:0] pix_mem [int];
  int                 written_addrs [$];

  blit_rsp_t   owed_results [$];
  dir_row_t    directed_plan [$];
  blit_rsp_t   oldest_rsp;

  int          error_count = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  bit          calm = 1'b0;
  int unsigned hold_asks = 0;

  // Frame sizes above the store dimension behave as the maximum.
  function automatic int eff_dim(logic [8:0] v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
  endfunction

  function automatic blit_req_t req_word(req_e kind, int x, int y, int w, int h, bit u,
                                         int c0, int c1, int c2, int c3);
    blit_req_t rq;
    rq.kind = kind;
    rq.x = x;
    rq.y = y;
    rq.w = w;
    rq.h = h;
    rq.untracked = u;
    rq.c0 = c0;
    rq.c1 = c1;
    rq.c2 = c2;
    rq.c3 = c3;
    return rq;
  endfunction

  function automatic blit_rsp_t rsp_word(status_e st, bit done, bit rv, int rx, int ry,
                                         int rw, int rh, int r, int g, int b);
    blit_rsp_t o;
    o.status = st;
    o.done = done;
    o.rv = rv;
    o.rx = rx;
    o.ry = ry;
    o.rw = rw;
    o.rh = rh;
    o.r = r;
    o.g = g;
    o.b = b;
    return o;
  endfunction

  // Random content in every field, including the ones the request kind ignores.
  function automatic blit_req_t random_word(req_e kind);
    return req_word(kind, $urandom_range(255), $urandom_range(255), $urandom_range(256),
                    $urandom_range(256), $urandom_range(1), $urandom_range(255),
                    $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endfunction

  // Works out the result word of one accepted request and advances the state.
  function automatic blit_rsp_t blit_outcome(blit_req_t rq);
    blit_rsp_t o;
    int fw, fh, addr, lft, top, rgt, bot;
    logic [7:0] red, blue;
    o = '0;
    o.status = ST_OK;
    fw = eff_dim(reg_width);
    fh = eff_dim(reg_height);
    case (rq.kind)
      REQ_HEADER: begin
        // Any header abandons the fragment in progress, accepted or not.
        frag_live = 1'b0;
        if (rq.x >= fw || rq.y >= fh || int'(rq.x) + int'(rq.w) > fw ||
            int'(rq.y) + int'(rq.h) > fh) begin
          o.status = ST_REJECT;
        end else if (rq.w != 0 && rq.h != 0) begin
          if (!rq.untracked) begin
            if (!dirty_on) begin
              dirty_left = rq.x;
              dirty_top  = rq.y;
              dirty_wid  = rq.w;
              dirty_hgt  = rq.h;
              dirty_on   = 1'b1;
            end else begin
              // True bounding box of the old rectangle and the new fragment.
              lft = (int'(rq.x) < dirty_left) ? int'(rq.x) : dirty_left;
              top = (int'(rq.y) < dirty_top) ? int'(rq.y) : dirty_top;
              rgt = int'(rq.x) + int'(rq.w);
              if (dirty_left + dirty_wid > rgt) rgt = dirty_left + dirty_wid;
              bot = int'(rq.y) + int'(rq.h);
              if (dirty_top + dirty_hgt > bot) bot = dirty_top + dirty_hgt;
              dirty_left = lft;
              dirty_top  = top;
              dirty_wid  = rgt - lft;
              dirty_hgt  = bot - top;
            end
          end
          frag_live = 1'b1;
          frag_ox   = rq.x;
          frag_oy   = rq.y;
          frag_cols = rq.w;
          frag_rows = rq.h;
          cur_col   = 0;
          cur_row   = 0;
        end
      end
      REQ_PIXEL: begin
        if (!frag_live) begin
          o.status = ST_NO_FRAG;
        end else begin
          red  = reg_format[0] ? rq.c2 : rq.c0;
          blue = reg_format[0] ? rq.c0 : rq.c2;
          addr = (frag_oy + cur_row) * fw + frag_ox + cur_col;
          if (addr < FRAME_PIXELS_DEF) begin
            if (!pix_mem.exists(addr)) written_addrs.push_back(addr);
            pix_mem[addr] = {red, rq.c1, blue};
          end
          cur_col++;
          if (cur_col >= frag_cols) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= frag_rows) begin
              cur_row   = 0;
              frag_live = 1'b0;
              o.done    = 1'b1;
            end
          end
        end
      end
      REQ_CLEAR: begin
        dirty_on   = 1'b0;
        dirty_left = 0;
        dirty_top  = 0;
        dirty_wid  = 0;
        dirty_hgt  = 0;
      end
      REQ_READ: begin
        if (rq.x >= fw || rq.y >= fh) begin
          o.status = ST_REJECT;
        end else begin
          addr = int'(rq.y) * fw + int'(rq.x);
          if (addr < FRAME_PIXELS_DEF && pix_mem.exists(addr)) begin
            {o.r, o.g, o.b} = pix_mem[addr];
          end
        end
      end
    endcase
    o.rv = dirty_on;
    o.rx = dirty_left[7:0];
    o.ry = dirty_top[7:0];
    o.rw = dirty_wid[8:0];
    o.rh = dirty_hgt[8:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Called just after a rising edge; returns just after the edge
  // at which the word was taken, with valid still high so that a following
  // word can go out back to back. The prediction is queued at that same edge.
  // ---------------------------------------------------------------------------
  task automatic send_word(blit_req_t rq);
    while (!calm && $urandom_range(99) < 38) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= rq.kind;
    req_bus.pos_x     <= rq.x;
    req_bus.pos_y     <= rq.y;
    req_bus.size_w    <= rq.w;
    req_bus.size_h    <= rq.h;
    req_bus.untracked <= rq.untracked;
    req_bus.chan0     <= rq.c0;
    req_bus.chan1     <= rq.c1;
    req_bus.chan2     <= rq.c2;
    req_bus.chan3     <= rq.c3;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    owed_results.push_back(blit_outcome(rq));
    words_sent++;
  endtask

  // A read of a pixel that is known to be written, or one outside the frame.
  // A read that would land on a never-written store word is turned into a clear.
  task automatic send_read();
    blit_req_t rq;
    int fw, fh, a;
    fw = eff_dim(reg_width);
    fh = eff_dim(reg_height);
    rq = random_word(REQ_READ);
    if (fw != 0 && written_addrs.size() != 0 && $urandom_range(9) < 7) begin
      a = written_addrs[$urandom_range(written_addrs.size() - 1)];
      rq.x = a % fw;
      rq.y = a / fw;
    end
    if (rq.x < fw && rq.y < fh && !pix_mem.exists(int'(rq.y) * fw + int'(rq.x))) begin
      rq.kind = REQ_CLEAR;
    end
    send_word(rq);
  endtask

  // Stops offering words and waits until every owed result has come back,
  // plus a short margin so the pipeline is surely empty.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(cfg_e idx, logic [8:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PIXEL_FORMAT: reg_format = val[1:0];
      CFG_FRAME_WIDTH:  reg_width  = val;
      CFG_FRAME_HEIGHT: reg_height = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The receiver stalls at random, except in calm phases, and on
  // request holds ready low for a long stretch so that both pipeline stages
  // fill and the block drops req_bus.ready.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_seen;
    hold_seen = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        repeat (HOLD_CYCLES) begin
          rsp_bus.ready <= 1'b0;
          @(posedge clk_i);
        end
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Every result word taken is compared with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (owed_results.size() == 0) begin
        $error("result word arrived with no request outstanding");
        error_count++;
      end else begin
        oldest_rsp = owed_results.pop_front();
        results_seen++;
        check_field("status", oldest_rsp.status, rsp_bus.status);
        check_field("frag_done", oldest_rsp.done, rsp_bus.frag_done);
        check_field("rect_valid", oldest_rsp.rv, rsp_bus.rect_valid);
        check_field("rect_x", oldest_rsp.rx, rsp_bus.rect_x);
        check_field("rect_y", oldest_rsp.ry, rsp_bus.rect_y);
        check_field("rect_w", oldest_rsp.rw, rsp_bus.rect_w);
        check_field("rect_h", oldest_rsp.rh, rsp_bus.rect_h);
        check_field("read_r", oldest_rsp.r, rsp_bus.read_r);
        check_field("read_g", oldest_rsp.g, rsp_bus.read_g);
        check_field("read_b", oldest_rsp.b, rsp_bus.read_b);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, then one random phase per setting.
  // ---------------------------------------------------------------------------
  initial begin
    int p, k, npix, fw, fh, phase_end;
    bit held;
    blit_req_t rq;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_PIXEL_FORMAT;
    cfg_data_i        <= '0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_HEADER;
    req_bus.pos_x     <= '0;
    req_bus.pos_y     <= '0;
    req_bus.size_w    <= '0;
    req_bus.size_h    <= '0;
    req_bus.untracked <= 1'b0;
    req_bus.chan0     <= '0;
    req_bus.chan1     <= '0;
    req_bus.chan2     <= '0;
    req_bus.chan3     <= '0;

    // Predictor after reset: RGB order, 256 by 256, nothing dirty, no fragment.
    reg_format = 2'd0;
    reg_width  = 9'd256;
    reg_height = 9'd256;
    dirty_on   = 1'b0;
    dirty_left = 0;
    dirty_top  = 0;
    dirty_wid  = 0;
    dirty_hgt  = 0;
    frag_live  = 1'b0;
    frag_ox    = 0;
    frag_oy    = 0;
    frag_cols  = 0;
    frag_rows  = 0;
    cur_col    = 0;
    cur_row    = 0;

    // Directed rows. The first nine and the clear/pixel pair near the end carry
    // their result; the rest go through the predictor.
    directed_plan.push_back('{req_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    // A pixel with no fragment open is ignored.
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 9, 9, 9, 9), 1'b1,
                              rsp_word(ST_NO_FRAG, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    // Right edge one past the frame: rejected.
    directed_plan.push_back('{req_word(REQ_HEADER, 1, 0, 256, 1, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_REJECT, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    // Bottom right corner pixel opens the dirty rectangle.
    directed_plan.push_back('{req_word(REQ_HEADER, 255, 255, 1, 1, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 1, 255, 255, 1, 1, 0, 0, 0)});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'hFF, 8'h00, 8'hAA, 8'h55),
                              1'b1, rsp_word(ST_OK, 1, 1, 255, 255, 1, 1, 0, 0, 0)});
    directed_plan.push_back('{req_word(REQ_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 1, 255, 255, 1, 1, 8'hFF, 8'h00, 8'hAA)});
    // Empty fragments are accepted but change nothing.
    directed_plan.push_back('{req_word(REQ_HEADER, 0, 0, 256, 0, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 1, 255, 255, 1, 1, 0, 0, 0)});
    directed_plan.push_back('{req_word(REQ_HEADER, 0, 0, 0, 256, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 1, 255, 255, 1, 1, 0, 0, 0)});
    // Untracked background fragment leaves the rectangle alone.
    directed_plan.push_back('{req_word(REQ_HEADER, 0, 0, 2, 2, 1, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 1, 255, 255, 1, 1, 0, 0, 0)});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00),
                              1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                              1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'h01, 8'h80, 8'h7F, 8'h00),
                              1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'hAA, 8'h55, 8'hAA, 8'h55),
                              1'b0, '0});
    directed_plan.push_back('{req_word(REQ_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // A fragment left of and above the rectangle: the union must keep the far edges.
    directed_plan.push_back('{req_word(REQ_HEADER, 10, 20, 3, 1, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 1, 2, 3, 4), 1'b0, '0});
    // A rejected header still abandons the open fragment.
    directed_plan.push_back('{req_word(REQ_HEADER, 200, 100, 8, 200, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 5, 6, 7, 8), 1'b0, '0});
    // Full frame fragment, opened and then abandoned after one pixel.
    directed_plan.push_back('{req_word(REQ_HEADER, 0, 0, 256, 256, 1, 0, 0, 0, 0), 1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'h12, 8'h34, 8'h56, 0),
                              1'b0, '0});
    // A clear in the middle of a fragment keeps the fragment open.
    directed_plan.push_back('{req_word(REQ_HEADER, 5, 5, 1, 2, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'h21, 8'h43, 8'h65, 0),
                              1'b0, '0});
    directed_plan.push_back('{req_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              rsp_word(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    directed_plan.push_back('{req_word(REQ_PIXEL, 0, 0, 0, 0, 0, 8'h87, 8'hA9, 8'hCB, 0),
                              1'b1, rsp_word(ST_OK, 1, 0, 0, 0, 0, 0, 0, 0, 0)});
    directed_plan.push_back('{req_word(REQ_READ, 5, 6, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      send_word(directed_plan[i].rq);
      if (directed_plan[i].typed) owed_results[owed_results.size() - 1] = directed_plan[i].want;
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_PIXEL_FORMAT, 9'(PH_FMT[p]));
      write_reg(CFG_FRAME_WIDTH, 9'(PH_W[p]));
      write_reg(CFG_FRAME_HEIGHT, 9'(PH_H[p]));
      // The first phase runs with no random idling on either side; the long receiver hold still happens.
      calm = (p == 0);
      fw = eff_dim(reg_width);
      fh = eff_dim(reg_height);
      held = 1'b0;
      phase_end = words_sent + PH_LEN[p];

      // The fragment left open by the previous phase continues under the new
      // frame size, so its pixels land at addresses computed with the new width.
      repeat (3) send_word(random_word(REQ_PIXEL));

      while (words_sent < phase_end) begin
        if (!held && words_sent + PH_LEN[p] - phase_end >= 20) begin
          // Ask the receiver for a long hold while we keep offering words.
          hold_asks <= hold_asks + 1;
          held = 1'b1;
        end
        k = $urandom_range(99);
        if (k < 60 && fw != 0 && fh != 0) begin
          // Well-formed fragment with random pixel content, mostly small.
          rq = random_word(REQ_HEADER);
          if ($urandom_range(19) == 0) begin
            rq.w = $urandom_range(fw, 1);
            rq.h = 1;
          end else begin
            rq.w = $urandom_range((fw < 6) ? fw : 6, 1);
            rq.h = $urandom_range((fh < 4) ? fh : 4, 1);
          end
          rq.x = $urandom_range(fw - int'(rq.w));
          rq.y = $urandom_range(fh - int'(rq.h));
          rq.untracked = ($urandom_range(3) == 0);
          send_word(rq);
          npix = int'(rq.w) * int'(rq.h);
          // Now and then the pixel stream is cut short.
          if ($urandom_range(9) == 0) npix = $urandom_range(npix - 1);
          repeat (npix) begin
            if ($urandom_range(15) == 0) send_read();
            send_word(random_word(REQ_PIXEL));
          end
        end else if (k < 75) begin
          send_read();
        end else if (k < 80) begin
          send_word(random_word(REQ_CLEAR));
        end else if (k < 92) begin
          // Header with random geometry: often rejected, sometimes a large fragment.
          send_word(random_word(REQ_HEADER));
        end else begin
          send_word(random_word(REQ_PIXEL));
        end
      end

      // Leave a small fragment open across the register change.
      rq = random_word(REQ_HEADER);
      rq.x = 0;
      rq.y = 0;
      rq.w = (fw < 2) ? fw : 2;
      rq.h = (fh < 2) ? fh : 2;
      send_word(rq);
      send_word(random_word(REQ_PIXEL));
    end

    drain();
    calm = 1'b0;

    $display("Covered %0d request words (%0d directed) and %0d results across %0d settings,",
             words_sent, directed_plan.size(), results_seen, NUM_PHASES + 1);
    $display("all four pixel orders and frame sizes from 0 to 511, with long receiver holds.");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/fbdr_pkg.sv
src/fbdr_req_if.sv
src/fbdr_store.sv
src/frame_blit_dirty_rect.sv
bench/frame_blit_dirty_rect_test.sv
